FILE: design/sefr_pkg.sv
// ----------------------------------------------------------------------------
// sefr_pkg
// Shared types and constants for the SOH/EOT frame receiver.
// ----------------------------------------------------------------------------
package sefr_pkg;

  localparam int BYTE_W = 8;

  // configuration register indexes
  localparam logic REG_START_CODE = 1'b0;
  localparam logic REG_END_CODE   = 1'b1;

  localparam logic [BYTE_W-1:0] START_CODE_RST = 8'h01;
  localparam logic [BYTE_W-1:0] END_CODE_RST   = 8'h04;

  typedef enum logic [1:0] {
    S_RUN,   // taking received bytes
    S_ERR,   // error result pending
    S_RD,    // frame buffer read issued
    S_LOAD   // read data valid, moving to output register
  } state_t;

  typedef struct packed {
    logic              load;
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              error;
  } out_load_t;

endpackage

FILE: design/sefr_ram.sv
// ----------------------------------------------------------------------------
// sefr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sefr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/sefr_ctrl.sv
// ----------------------------------------------------------------------------
// sefr_ctrl
// Frame sequencer: fills the frame buffer, checks length on the end byte and
// sweeps the buffer out to the output register, or loads an error result.
// ----------------------------------------------------------------------------
module sefr_ctrl import sefr_pkg::*; #(
  parameter int FRAME_DEPTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [BYTE_W-1:0]              start_code,
  input  logic [BYTE_W-1:0]              end_code,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [BYTE_W-1:0]              rx_byte,
  input  logic                           slot_free,
  output out_load_t                      out_load,
  output logic                           ram_we,
  output logic [$clog2(FRAME_DEPTH)-1:0] ram_waddr,
  output logic [BYTE_W-1:0]              ram_wdata,
  output logic                           ram_re,
  output logic [$clog2(FRAME_DEPTH)-1:0] ram_raddr,
  input  logic [BYTE_W-1:0]              ram_rdata
);

  localparam int IW = $clog2(FRAME_DEPTH);
  localparam int CW = (IW + 1 > BYTE_W) ? IW + 1 : BYTE_W;

  state_t            state, state_next;
  logic              in_frame;
  logic [IW-1:0]     write_index;
  logic [IW-1:0]     rd_idx;
  logic [IW-1:0]     last_idx;
  logic [BYTE_W-1:0] len_byte;

  logic accept;
  logic is_start, is_end;
  logic overflow;
  logic bad_frame;
  logic rd_last;

  assign in_ready = (state == S_RUN);
  assign accept   = in_valid && in_ready;
  assign is_start = (rx_byte == start_code);
  assign is_end   = (rx_byte == end_code);
  assign overflow = (write_index >= IW'(FRAME_DEPTH - 1));
  // too short, or byte 2 disagrees with total length (start through end)
  assign bad_frame = (write_index < IW'(3)) ||
                     (CW'(len_byte) != (CW'(write_index) + CW'(1)));
  assign rd_last  = (rd_idx == last_idx);

  always_comb begin
    state_next = state;
    unique case (state)
      S_RUN: begin
        if (accept && in_frame) begin
          if (!is_end) begin
            if (overflow) state_next = S_ERR;
          end else if (bad_frame) begin
            state_next = S_ERR;
          end else begin
            state_next = S_RD;
          end
        end
      end
      S_ERR:  if (slot_free) state_next = S_RUN;
      S_RD:   state_next = S_LOAD;
      S_LOAD: begin
        if (slot_free) state_next = rd_last ? S_RUN : S_RD;
      end
      default: state_next = S_RUN;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = write_index;
    ram_wdata = rx_byte;
    ram_re    = 1'b0;
    ram_raddr = rd_idx;
    out_load  = '0;
    unique case (state)
      S_RUN: begin
        if (accept) begin
          if (!in_frame) begin
            ram_we    = is_start;
            ram_waddr = '0;
          end else if (!is_end) begin
            ram_we = !overflow;
          end else begin
            ram_we = !bad_frame;
          end
        end
      end
      S_ERR: begin
        out_load.load  = slot_free;
        out_load.last  = 1'b1;
        out_load.error = 1'b1;
      end
      S_RD: ram_re = 1'b1;
      S_LOAD: begin
        out_load.load = slot_free;
        out_load.data = ram_rdata;
        out_load.last = rd_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_RUN;
      in_frame    <= 1'b0;
      write_index <= IW'(1);
      rd_idx      <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (!in_frame) begin
          if (is_start) begin
            in_frame    <= 1'b1;
            write_index <= IW'(1);
          end
        end else if (!is_end && !overflow) begin
          write_index <= write_index + IW'(1);
        end else begin
          in_frame    <= 1'b0;
          write_index <= IW'(1);
          rd_idx      <= '0;
        end
      end
      if (state == S_LOAD && slot_free && !rd_last) begin
        rd_idx <= rd_idx + IW'(1);
      end
    end
  end

  // payload side: length byte and final read slot
  always_ff @(posedge clk) begin
    if (accept && in_frame && !is_end && write_index == IW'(2)) begin
      len_byte <= rx_byte;
    end
    if (accept && in_frame && is_end) begin
      last_idx <= write_index;
    end
  end

endmodule

FILE: design/soh_eot_frame_receiver.sv
// ----------------------------------------------------------------------------
// soh_eot_frame_receiver
// Length-checked SOH/EOT deframer: buffers a frame, checks its length byte
// and replays it, or returns a single error result.
// ----------------------------------------------------------------------------
//  channel  signals                               direction
//  cfg      cfg_we, cfg_index, cfg_data           in, write only
//  rx       in_valid/in_ready, rx_byte            in
//  frame    out_valid/out_ready, frame_byte,      out
//           frame_last, frame_error
//
//  An end byte that passes the check starts a replay of the frame buffer:
//  each frame byte is a RAM read, then a load into the output register,
//  which waits for a free output slot; rx is not ready during the replay.
//  An error result is loaded once the output register is free.
//  A stalled output only holds the sequencer when a new request is due.
//  Reset clears the sequencer; the frame buffer is not cleared.
// ----------------------------------------------------------------------------
module soh_eot_frame_receiver import sefr_pkg::*; #(
  parameter int FRAME_DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [BYTE_W-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] rx_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] frame_byte,
  output logic              frame_last,
  output logic              frame_error
);

  localparam int IW = $clog2(FRAME_DEPTH);

  logic [BYTE_W-1:0] start_code;
  logic [BYTE_W-1:0] end_code;
  logic              slot_free;
  out_load_t         out_load;
  logic              ram_we, ram_re;
  logic [IW-1:0]     ram_waddr, ram_raddr;
  logic [BYTE_W-1:0] ram_wdata, ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_code <= START_CODE_RST;
      end_code   <= END_CODE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_CODE: start_code <= cfg_data;
        REG_END_CODE:   end_code   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign slot_free = !out_valid || out_ready;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load.load) begin
      frame_byte  <= out_load.data;
      frame_last  <= out_load.last;
      frame_error <= out_load.error;
    end
  end

  sefr_ctrl #(
    .FRAME_DEPTH(FRAME_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start_code (start_code),
    .end_code   (end_code),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .slot_free  (slot_free),
    .out_load   (out_load),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  sefr_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(FRAME_DEPTH)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // buffer is never written during a replay read
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("frame buffer written while being read");

  // a result is never loaded over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load.load && out_valid |-> out_ready)
    else $error("output register overwritten");

  // a new request is never taken while a replay read is outstanding
  a_read_blocks_rx: assert property (@(posedge clk) disable iff (rst)
    ram_re |=> !in_ready)
    else $error("rx accepted during replay");

  // error results carry a zero byte and close the result
  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_error |-> frame_last && (frame_byte == '0))
    else $error("malformed error result");

endmodule
